FILE: sv/odr_pkg.sv
// Shared constants, types and the arctangent table for the odometry dead-reckoning block.
// No dependencies; imported by odr_cordic and odometry_dead_reckoning.
package odr_pkg;

    localparam int DIST_FRAC_BITS = 16;
    localparam int ANGLE_BITS     = 16;
    localparam int POS_BITS       = 48;
    localparam int CORDIC_STAGES  = 16;

    localparam int ITER_W   = $clog2(CORDIC_STAGES);
    localparam int ROT_W    = 32;
    localparam int DIST_W   = 32;
    localparam int VEL_W    = 32;
    localparam int DELTA_W  = DIST_W + 1;
    localparam int JUMP_W   = 31;
    localparam int PART_W   = 17;
    localparam int PROD_W   = DELTA_W + PART_W;
    localparam int ACC_W    = DELTA_W + ROT_W + 1;
    localparam int SC_FRAC  = 30;
    localparam int SC_W     = ACC_W - SC_FRAC;
    localparam int SUM_W    = ((POS_BITS > SC_W) ? POS_BITS : SC_W) + 2;
    localparam int IN_W     = DIST_W + ANGLE_BITS + 2 * VEL_W;
    localparam int OUT_W    = 2 * POS_BITS + 2 * ANGLE_BITS + 3 * VEL_W;

    localparam logic signed [ROT_W-1:0] GAIN_Q30 = 32'sd652032874;
    localparam logic [JUMP_W-1:0] JUMP_RESET = JUMP_W'(50 << DIST_FRAC_BITS);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (SC_FRAC - 1));

    localparam logic signed [SUM_W-1:0] POS_MAX_S =
        {{(SUM_W-POS_BITS+1){1'b0}}, {(POS_BITS-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN_S = ~POS_MAX_S;
    localparam logic signed [SC_W-1:0] VEL_MAX_S =
        {{(SC_W-VEL_W+1){1'b0}}, {(VEL_W-1){1'b1}}};
    localparam logic signed [SC_W-1:0] VEL_MIN_S = ~VEL_MAX_S;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_START,
        S_ROT,
        S_MUL_LO,
        S_MUL_HI,
        S_FINISH,
        S_OUT
    } odr_state_t;

    typedef struct packed {
        logic                  start;
        logic [ANGLE_BITS-1:0] angle;
    } odr_rot_req_t;

    typedef struct packed {
        logic             done;
        logic [ROT_W-1:0] co;
        logic [ROT_W-1:0] si;
    } odr_rot_rsp_t;

    function automatic logic [ROT_W-1:0] atan_lookup(input logic [ITER_W-1:0] idx);
        logic [4:0]       i;
        logic [ROT_W-1:0] v;
        i = 5'(idx);
        case (i)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/odometry_dead_reckoning.sv
// Odometry dead-reckoning integrator top level: sequencer, shared 33x17 multiplier, pose state.
// Depends on odr_pkg and odr_cordic.
//
//  channel   dir   width  handshake                   payload
//  s_axis    in    112    s_axis_tvalid/s_axis_tready odometry reading
//  m_axis    out   224    m_axis_tvalid/m_axis_tready pose result
//  cfg       in    31     cfg_valid/cfg_ready         jump limit, Q15.16
//
// A reading runs through the 16 CORDIC stages and four products of two partial multiplies
// each through one multiplier; the first reading after reset needs only the two velocity
// products, and a reading dropped by the jump limit skips both. No new reading is taken until the last one is done.
// The result waits in an output register; a stalled m_axis holds the sequencer in its
// last state only until that register frees. Reset clears the pose and the limit to 50.0.
module odometry_dead_reckoning
    import odr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // distance[31:0], bearing[47:32], trans_velocity[79:48], rot_velocity[111:80]
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // x_position[47:0], y_position[95:48], heading[111:96], velocity_x[143:112],
    // velocity_y[175:144], turn_rate[207:176], joint_angle[223:208]
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [JUMP_W-1:0] cfg_data
);

    odr_state_t state_reg;
    odr_state_t state_next;

    odr_rot_req_t rot_req;
    odr_rot_rsp_t rot_rsp;

    logic [JUMP_W-1:0]     jump_limit_reg;
    logic                  started_reg;
    logic [ANGLE_BITS-1:0] ref_bearing_reg;
    logic [DIST_W-1:0]     prev_dist_reg;
    logic [ANGLE_BITS-1:0] prev_rel_reg;
    logic [ANGLE_BITS-1:0] heading_reg;
    logic [POS_BITS-1:0]   x_reg;
    logic [POS_BITS-1:0]   y_reg;
    logic [1:0]            prod_idx_reg;
    logic                  out_valid_reg;

    logic [DIST_W-1:0]       dist_reg;
    logic [ANGLE_BITS-1:0]   brg_reg;
    logic [VEL_W-1:0]        tvel_reg;
    logic [VEL_W-1:0]        rvel_reg;
    logic [DELTA_W-1:0]      dd_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [VEL_W-1:0]        vx_reg;
    logic [VEL_W-1:0]        vy_reg;
    logic [OUT_W-1:0]        out_data_reg;

    logic                  in_xfer;
    logic                  load_out;
    logic [DIST_W-1:0]     s_dist;
    logic [ANGLE_BITS-1:0] s_brg;
    logic [VEL_W-1:0]      s_tvel;
    logic [VEL_W-1:0]      s_rvel;

    logic [DELTA_W-1:0]      mag;
    logic                    jump;
    logic [ANGLE_BITS-1:0]   rel;
    logic [ANGLE_BITS-1:0]   dh;
    logic [DELTA_W-1:0]      a_op;
    logic [ROT_W-1:0]        c_op;
    logic [PART_W-1:0]       b_op;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] rnd;
    logic signed [SC_W-1:0]  sc;
    logic signed [POS_BITS-1:0] xy_sel;
    logic signed [SUM_W-1:0] pos_sum;
    logic [POS_BITS-1:0]     pos_sat;
    logic [VEL_W-1:0]        vel_sat;

    assign s_dist = s_axis_tdata[31:0];
    assign s_brg  = s_axis_tdata[47:32];
    assign s_tvel = s_axis_tdata[79:48];
    assign s_rvel = s_axis_tdata[111:80];

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    odr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rot_req),
        .rsp   (rot_rsp)
    );

    // jump test and heading update
    assign mag  = dd_reg[DELTA_W-1] ? (~dd_reg + 1'b1) : dd_reg;
    assign jump = mag > {{(DELTA_W-JUMP_W){1'b0}}, jump_limit_reg};
    assign rel  = brg_reg - ref_bearing_reg;
    assign dh   = rel - prev_rel_reg;

    // shared multiplier: index 0 dd*cos, 1 dd*sin, 2 v*cos, 3 v*sin
    assign a_op = prod_idx_reg[1] ? {tvel_reg[VEL_W-1], tvel_reg} : dd_reg;
    assign c_op = prod_idx_reg[0] ? rot_rsp.si : rot_rsp.co;
    assign b_op = (state_reg == S_MUL_HI) ? {c_op[ROT_W-1], c_op[ROT_W-1:16]}
                                          : {1'b0, c_op[15:0]};
    assign prod     = $signed(a_op) * $signed(b_op);
    assign prod_ext = ACC_W'(prod);

    assign rnd = acc_reg + ROUND_HALF;
    assign sc  = rnd[ACC_W-1:SC_FRAC];

    assign xy_sel  = prod_idx_reg[0] ? $signed(y_reg) : $signed(x_reg);
    assign pos_sum = SUM_W'(xy_sel) + SUM_W'(sc);

    always_comb
    begin
        priority if (pos_sum > POS_MAX_S)
            pos_sat = POS_MAX_S[POS_BITS-1:0];
        else if (pos_sum < POS_MIN_S)
            pos_sat = POS_MIN_S[POS_BITS-1:0];
        else
            pos_sat = pos_sum[POS_BITS-1:0];
    end

    always_comb
    begin
        priority if (sc > VEL_MAX_S)
            vel_sat = VEL_MAX_S[VEL_W-1:0];
        else if (sc < VEL_MIN_S)
            vel_sat = VEL_MIN_S[VEL_W-1:0];
        else
            vel_sat = sc[VEL_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = started_reg ? S_CHECK : S_START;
            end
            S_CHECK:  state_next = jump ? S_IDLE : S_START;
            S_START:  state_next = S_ROT;
            S_ROT:
            begin
                if (rot_rsp.done)
                    state_next = S_MUL_LO;
            end
            S_MUL_LO: state_next = S_MUL_HI;
            S_MUL_HI: state_next = S_FINISH;
            S_FINISH: state_next = (prod_idx_reg == 2'd3) ? S_OUT : S_MUL_LO;
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        rot_req.start = (state_reg == S_START);
        rot_req.angle = heading_reg;
        load_out      = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            jump_limit_reg  <= JUMP_RESET;
            started_reg     <= 1'b0;
            ref_bearing_reg <= '0;
            prev_dist_reg   <= '0;
            prev_rel_reg    <= '0;
            heading_reg     <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            prod_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                jump_limit_reg <= cfg_data;

            if (in_xfer)
            begin
                if (!started_reg)
                begin
                    started_reg     <= 1'b1;
                    ref_bearing_reg <= s_brg;
                    prev_dist_reg   <= s_dist;
                    prev_rel_reg    <= '0;
                    heading_reg     <= '0;
                    x_reg           <= '0;
                    y_reg           <= '0;
                    prod_idx_reg    <= 2'd2;
                end
                else
                    prod_idx_reg <= 2'd0;
            end

            if (state_reg == S_CHECK && !jump)
            begin
                prev_dist_reg <= dist_reg;
                prev_rel_reg  <= rel;
                heading_reg   <= heading_reg + dh;
            end

            if (state_reg == S_FINISH)
            begin
                prod_idx_reg <= prod_idx_reg + 1'b1;
                if (prod_idx_reg == 2'd0)
                    x_reg <= pos_sat;
                if (prod_idx_reg == 2'd1)
                    y_reg <= pos_sat;
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            dist_reg <= s_dist;
            brg_reg  <= s_brg;
            tvel_reg <= s_tvel;
            rvel_reg <= s_rvel;
            dd_reg   <= {s_dist[DIST_W-1], s_dist} - {prev_dist_reg[DIST_W-1], prev_dist_reg};
        end

        if (state_reg == S_MUL_LO)
            acc_reg <= prod_ext;
        else if (state_reg == S_MUL_HI)
            acc_reg <= acc_reg + (prod_ext <<< 16);

        if (state_reg == S_FINISH)
        begin
            if (prod_idx_reg == 2'd2)
                vx_reg <= vel_sat;
            if (prod_idx_reg == 2'd3)
                vy_reg <= vel_sat;
        end

        if (load_out)
            out_data_reg <= {brg_reg, rvel_reg, vy_reg, vx_reg, heading_reg, y_reg, x_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: sv/odr_cordic.sv
// Iterative rotation-mode CORDIC: one shift/add stage per cycle, gives cos and sin in Q2.30.
// Depends on odr_pkg (stage count, gain, arctangent table, request/response structs).
module odr_cordic
    import odr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  odr_rot_req_t req,
    output odr_rot_rsp_t rsp
);

    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              neg_reg;

    logic signed [ROT_W-1:0] x_reg;
    logic signed [ROT_W-1:0] y_reg;
    logic signed [ROT_W-1:0] z_reg;
    logic        [ROT_W-1:0] co_reg;
    logic        [ROT_W-1:0] si_reg;

    logic        [ROT_W-1:0] angle_w;
    logic                    neg_w;
    logic        [ROT_W-1:0] z_start;
    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;
    logic signed [ROT_W-1:0] at;

    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STAGES - 1);

    // fold the second and third quarter onto the others; results negated at the end
    assign angle_w = {req.angle, {(ROT_W-ANGLE_BITS){1'b0}}};
    assign neg_w   = angle_w[ROT_W-1] ^ angle_w[ROT_W-2];
    assign z_start = {angle_w[ROT_W-1] ^ neg_w, angle_w[ROT_W-2:0]};

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = $signed(atan_lookup(iter_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                fin_reg  <= 1'b0;
                iter_reg <= '0;
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == LAST_ITER)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg   <= GAIN_Q30;
            y_reg   <= '0;
            z_reg   <= $signed(z_start);
            neg_reg <= neg_w;
        end
        else if (busy_reg)
        begin
            if (!z_reg[ROT_W-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
        else if (fin_reg)
        begin
            co_reg <= neg_reg ? -x_reg : x_reg;
            si_reg <= neg_reg ? -y_reg : y_reg;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.co   = co_reg;
    assign rsp.si   = si_reg;

endmodule

FILE: bench/odometry_dead_reckoning_tb.sv
// Self-checking bench for odometry_dead_reckoning: directed readings, then random tracks.
// The pose predictor, CORDIC included, is built in here; needs odr_pkg and the block's RTL.
module odometry_dead_reckoning_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import odr_pkg::*;

    localparam int     POSE_W         = 224;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     REPORT_LIMIT   = 10;
    localparam int     TRACK_RESULTS  = 170;
    localparam longint CORDIC_GAIN    = 64'sd652032874;
    localparam longint HALF_Q30       = 64'sd536870912;
    localparam longint POS_MAX        = (64'sd1 <<< 47) - 1;
    localparam longint POS_MIN        = -POS_MAX - 1;
    localparam longint VEL_MAX        = 64'sd2147483647;
    localparam longint VEL_MIN        = -VEL_MAX - 1;
    localparam logic [30:0] DEFAULT_LIMIT = 31'd3276800;
    localparam logic [30:0] MAX_LIMIT     = 31'h7FFF_FFFF;
    localparam longint CORDIC_ATAN [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861
    };

    typedef struct packed {
        logic signed [31:0] rot_velocity;
        logic signed [31:0] trans_velocity;
        logic signed [15:0] bearing;
        logic signed [31:0] distance;
    } reading_t;

    typedef struct packed {
        logic signed [15:0] joint_angle;
        logic signed [31:0] turn_rate;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_x;
        logic signed [15:0] heading;
        logic signed [47:0] y_position;
        logic signed [47:0] x_position;
    } pose_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [JUMP_W-1:0] cfg_data = '0;

    // predictor state
    bit          odo_started;
    logic [15:0] ref_bearing;
    longint      accepted_dist;
    logic [15:0] last_rel_bearing;
    logic [15:0] heading_acc;
    longint      x_acc;
    longint      y_acc;
    longint      jump_limit;

    pose_t expected_poses[$];
    pose_t seen_pose;
    pose_t want_pose;
    int    error_count;
    int    quiet_cycles;
    int    stall_left;
    bit    gaps_on;
    bit    sink_stalls;

    odometry_dead_reckoning dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 85)
            return $urandom_range(1, 3);
        else if (sel < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic longint round_q30(input longint a, input longint c);
        return (a * c + HALF_Q30) >>> 30;
    endfunction

    // rotation-mode CORDIC, Q2.30 out; second and third quadrants folded by a half turn
    function automatic void heading_sincos(input logic [15:0] h, output longint co,
                                           output longint si);
        logic [31:0] a;
        bit          flip;
        longint      cx, cy, cz, dx, dy;
        a = {h, 16'h0000};
        flip = (a[31:30] == 2'b01) || (a[31:30] == 2'b10);
        if (flip)
            a = a + 32'h8000_0000;
        cx = CORDIC_GAIN;
        cy = 0;
        cz = longint'($signed(a));
        for (int i = 0; i < 16; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0)
            begin
                cx -= dx;
                cy += dy;
                cz -= CORDIC_ATAN[i];
            end
            else
            begin
                cx += dx;
                cy -= dy;
                cz += CORDIC_ATAN[i];
            end
        end
        co = flip ? -cx : cx;
        si = flip ? -cy : cy;
    endfunction

    function automatic bit integrate_reading(input reading_t r, output pose_t p);
        longint      reading_dist, tvel, dd, mag, co, si, v;
        logic [15:0] brg, rel;
        p = '0;
        reading_dist = longint'(r.distance);
        tvel = longint'(r.trans_velocity);
        brg = r.bearing;
        if (!odo_started)
        begin
            odo_started = 1'b1;
            ref_bearing = brg;
            accepted_dist = reading_dist;
            last_rel_bearing = '0;
            heading_acc = '0;
            x_acc = 0;
            y_acc = 0;
        end
        else
        begin
            dd = reading_dist - accepted_dist;
            mag = (dd < 0) ? -dd : dd;
            if (mag > jump_limit)
                return 1'b0;
            rel = brg - ref_bearing;
            heading_acc = heading_acc + (rel - last_rel_bearing);
            heading_sincos(heading_acc, co, si);
            x_acc = clamp(x_acc + round_q30(dd, co), POS_MIN, POS_MAX);
            y_acc = clamp(y_acc + round_q30(dd, si), POS_MIN, POS_MAX);
            accepted_dist = reading_dist;
            last_rel_bearing = rel;
        end
        heading_sincos(heading_acc, co, si);
        p.x_position = x_acc[47:0];
        p.y_position = y_acc[47:0];
        p.heading = heading_acc;
        v = clamp(round_q30(tvel, co), VEL_MIN, VEL_MAX);
        p.velocity_x = v[31:0];
        v = clamp(round_q30(tvel, si), VEL_MIN, VEL_MAX);
        p.velocity_y = v[31:0];
        p.turn_rate = r.rot_velocity;
        p.joint_angle = r.bearing;
        return 1'b1;
    endfunction

    function automatic reading_t odo_reading(input logic [31:0] d, input logic [15:0] b,
                                             input logic [31:0] tv, input logic [31:0] rv);
        reading_t r;
        r.distance = d;
        r.bearing = b;
        r.trans_velocity = tv;
        r.rot_velocity = rv;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        if (error_count < REPORT_LIMIT)
            $display("%0t ns: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (want !== seen)
            flag_error($sformatf("%s mismatch: expected %h, got %h", name, want, seen));
    endtask

    // valid is left high after a transfer so back-to-back readings need no lowering
    task automatic send_reading(input reading_t r, output bit produced);
        pose_t p;
        int    gap;
        gap = (gaps_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= IN_W'(r);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        produced = integrate_reading(r, p);
        if (produced)
            expected_poses.push_back(p);
    endtask

    task automatic feed(input logic [31:0] d, input logic [15:0] b, input logic [31:0] tv,
                        input logic [31:0] rv);
        bit produced;
        send_reading(odo_reading(d, b, tv, rv), produced);
    endtask

    // a dropped reading leaves nothing to wait for, so allow the block time to finish it
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_jump_limit(input logic [30:0] value);
        settle_idle();
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        jump_limit = longint'(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_first_reading();
        feed(32'h0001_0000, 16'h1234, 32'h0002_0000, 32'h7FFF_FFFF);
    endtask

    task automatic test_jump_boundary();
        logic [31:0] base;
        base = 32'(accepted_dist);
        feed(base + 32'(DEFAULT_LIMIT), 16'h1234, 32'h0001_8000, 32'h8000_0000);
        feed(base + 32'(DEFAULT_LIMIT) * 2 + 1, 16'h1300, 32'h0001_0000, 32'h0000_0001);
        feed(base - 1, 16'h2000, 32'hFFFF_0000, 32'h0);
        feed(base, 16'h1334, 32'hFFFF_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_heading_quadrants();
        logic [15:0] raw [0:8] = '{16'h5233, 16'h5234, 16'h7FFF, 16'h8000, 16'h9234,
                                   16'hD233, 16'hD234, 16'h1233, 16'h1234};
        for (int i = 0; i < 9; i++)
            feed(32'(accepted_dist) + 32'h0000_8000, raw[i],
                 i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                 i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    endtask

    task automatic test_zero_limit();
        logic [31:0] base;
        write_jump_limit('0);
        base = 32'(accepted_dist);
        feed(base, 16'h0100, 32'h1234_5678, 32'h0);
        feed(base + 1, 16'h0200, 32'h1234_5678, 32'h0);
        feed(base - 1, 16'h0300, 32'h1234_5678, 32'h0);
        feed(base, 16'h0400, 32'hEDCB_A988, 32'h1);
    endtask

    // deltas at the 31-bit limit and beyond it, up to the full 33-bit span
    task automatic test_full_limit();
        write_jump_limit(MAX_LIMIT);
        feed(32'h0000_0000, 16'h1234, 32'h0001_0000, 32'h0);
        feed(32'h8000_0001, 16'h9234, 32'h0001_0000, 32'h0);
        feed(32'h0000_0000, 16'h1234, 32'h0001_0000, 32'h0);
        feed(32'h7FFF_FFFF, 16'h1234, 32'h0001_0000, 32'h0);
        feed(32'h8000_0000, 16'h1234, 32'h0001_0000, 32'h0);
        feed(32'hFFFF_FFFF, 16'h1234, 32'h0001_0000, 32'h0);
        feed(32'h0000_0000, 16'h9234, 32'h0001_0000, 32'h0);
    endtask

    function automatic logic [31:0] rand_velocity();
        if ($urandom_range(0, 4) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // mostly plausible tracks around the last accepted reading, some jumps and noise
    task automatic test_random_track(input logic [30:0] limit, input int results);
        reading_t r;
        longint   lim, mag;
        int       sel, produced_count;
        bit       produced;
        logic [15:0] accepted_brg;
        write_jump_limit(limit);
        produced_count = 0;
        while (produced_count < results)
        begin
            if (produced_count % 40 == 0)
            begin
                gaps_on = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            lim = jump_limit;
            sel = $urandom_range(0, 99);
            if (sel < 45)
                mag = $urandom_range(0, int'((lim < 262144) ? lim : 262144));
            else if (sel < 65)
                mag = $urandom_range(0, int'(lim));
            else if (sel < 75)
                mag = lim;
            else
                mag = lim + 1 + $urandom_range(0, 1000);
            if (sel >= 87)
                r.distance = $urandom;
            else
                r.distance = 32'(accepted_dist + ($urandom_range(0, 1) ? -mag : mag));
            accepted_brg = ref_bearing + last_rel_bearing;
            sel = $urandom_range(0, 99);
            if (sel < 60)
                r.bearing = accepted_brg + 16'($urandom_range(0, 4000)) - 16'd2000;
            else if (sel < 85)
                r.bearing = 16'($urandom);
            else
                r.bearing = accepted_brg + 16'h8000;
            r.trans_velocity = rand_velocity();
            r.rot_velocity = rand_velocity();
            send_reading(r, produced);
            if (produced)
                produced_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (sink_stalls && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            seen_pose = pose_t'(POSE_W'(m_axis_tdata));
            if (expected_poses.size() == 0)
                flag_error($sformatf("result with nothing expected: %h", seen_pose));
            else
            begin
                want_pose = expected_poses.pop_front();
                check_field("x_position", want_pose.x_position, seen_pose.x_position);
                check_field("y_position", want_pose.y_position, seen_pose.y_position);
                check_field("heading", want_pose.heading, seen_pose.heading);
                check_field("velocity_x", want_pose.velocity_x, seen_pose.velocity_x);
                check_field("velocity_y", want_pose.velocity_y, seen_pose.velocity_y);
                check_field("turn_rate", want_pose.turn_rate, seen_pose.turn_rate);
                check_field("joint_angle", want_pose.joint_angle, seen_pose.joint_angle);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("odometry_dead_reckoning_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        jump_limit = longint'(DEFAULT_LIMIT);
        gaps_on = 1'b0;
        sink_stalls = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_reading();
        test_jump_boundary();
        gaps_on = 1'b1;
        sink_stalls = 1'b1;
        test_heading_quadrants();
        test_zero_limit();
        test_full_limit();
        test_random_track(DEFAULT_LIMIT, TRACK_RESULTS);
        test_random_track(31'h0001_0000, TRACK_RESULTS);
        test_random_track(31'($urandom_range(0, 32'h7FFF_FFFF)), TRACK_RESULTS);
        test_random_track(MAX_LIMIT, TRACK_RESULTS);
        test_random_track(31'($urandom_range(1, 32'h0040_0000)), TRACK_RESULTS);
        settle_idle();
        if (error_count == 0 && expected_poses.size() == 0)
            $display("odometry_dead_reckoning_tb: PASS");
        else
            $display("odometry_dead_reckoning_tb: FAIL");
        $finish;
    end

endmodule

FILE: odometry_dead_reckoning.f
sv/odr_pkg.sv
sv/odr_cordic.sv
sv/odometry_dead_reckoning.sv
bench/odometry_dead_reckoning_tb.sv
